FILE: rtl/ksd_pkg.sv
// shared types, constants and helpers for the koch segment subdivider
// no dependencies; used by every module under rtl
package ksd_pkg;

    localparam int MAX_DEPTH   = 3;
    localparam int COORD_WIDTH = 16;
    localparam int CFG_WIDTH   = 2;

    // level counter holds 0..MAX_DEPTH, stack index holds 0..MAX_DEPTH-1
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // difference of two coordinates, and the width the saturating sums work in
    localparam int DW    = COORD_WIDTH + 1;
    localparam int SAT_W = COORD_WIDTH + 3;

    // divide by 3 as multiply by ceil(2^k/3) then shift, exact for |d| < 2^(k-1)
    localparam int DIV3_SHIFT = COORD_WIDTH + 2;
    localparam int RW         = DIV3_SHIFT - 1;
    localparam logic [RW-1:0] DIV3_RECIP =
        RW'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

    // sin 60 in q10
    localparam int Q_FRAC = 10;
    localparam logic signed [10:0] SIN_Q10 = 11'sd887;

    localparam logic [1:0] LAST_CHILD = 2'd3;

    // front to back queue
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef point_t [4:0] pts_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_in_t;

    typedef struct packed {
        coord_t pt0_x;
        coord_t pt0_y;
        coord_t pt1_x;
        coord_t pt1_y;
        coord_t pt2_x;
        coord_t pt2_y;
        coord_t pt3_x;
        coord_t pt3_y;
        coord_t pt4_x;
        coord_t pt4_y;
        logic   last_leaf;
    } leaf_out_t;

    typedef struct packed {
        seg_in_t        seg;
        logic [LW-1:0]  level;
    } q_item_t;

    // clamp to the signed coordinate range
    function automatic coord_t sat(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[COORD_WIDTH-1:0];
        else if (v < lo)
            return lo[COORD_WIDTH-1:0];
        else
            return v[COORD_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/ksd_front.sv
// front part: depth register, input acceptance, level classification, short queue
// depends on ksd_pkg
module ksd_front
    import ksd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 seg_valid,
    output logic                 seg_stall,
    input  seg_in_t              seg,
    output logic                 q_valid,
    input  logic                 q_pop,
    output q_item_t              q_item
);

    logic [CFG_WIDTH-1:0] depth_reg;
    q_item_t              entry_reg [QDEPTH];
    logic [QPW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]       count_reg, count_next;
    logic                 push;
    logic                 pop;
    logic [LW-1:0]        level;

    // levels above the supported maximum fold down to it
    always_comb
    begin
        if (int'(depth_reg) > MAX_DEPTH)
            level = LW'(MAX_DEPTH);
        else
            level = LW'(depth_reg);
    end

    assign seg_stall = (count_reg == QCW'(QDEPTH));
    assign push      = seg_valid && !seg_stall;
    assign pop       = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= CFG_WIDTH'(MAX_DEPTH);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                depth_reg <= cfg_data;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].seg   <= seg;
            entry_reg[wr_ptr_reg].level <= level;
        end
    end

    assign q_item  = entry_reg[rd_ptr_reg];
    assign q_valid = (count_reg != '0);

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= QCW'(QDEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue count overflow");

    property p_push_full;
        @(posedge clk) disable iff (!rst_n)
            (count_reg == QCW'(QDEPTH) && !pop) |=> (count_reg == QCW'(QDEPTH));
    endproperty
    a_push_full: assert property (p_push_full) else $error("queue lost an entry");

    property p_ptr_gap;
        @(posedge clk) disable iff (!rst_n)
            (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers out of step");

endmodule

FILE: rtl/ksd_geom.sv
// geometry pipeline: thirds, second third and apex of one segment in six stages
// depends on ksd_pkg
module ksd_geom
    import ksd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  point_t p0,
    input  point_t p4,
    output logic   done,
    output pts_t   res
);

    localparam int PW = COORD_WIDTH + RW;
    localparam int EW = DW + 11;
    localparam int TW = EW - Q_FRAC;

    logic [5:0] v_reg;

    // per axis: index 0 is x, 1 is y
    coord_t                  in0   [2];
    coord_t                  in4   [2];
    logic signed [DW-1:0]    dif   [2];
    logic signed [DW-1:0]    ndif  [2];

    coord_t                  a_p0_reg  [2];
    coord_t                  a_p4_reg  [2];
    logic [COORD_WIDTH-1:0]  a_mag_reg [2];
    logic                    a_neg_reg [2];

    coord_t                  b_p0_reg   [2];
    coord_t                  b_p4_reg   [2];
    logic [PW-1:0]           b_prod_reg [2];
    logic                    b_neg_reg  [2];

    logic [DW-1:0]           lpos [2];
    logic signed [DW-1:0]    lsig [2];
    logic signed [SAT_W-1:0] s1   [2];
    logic signed [SAT_W-1:0] s3   [2];
    coord_t                  c_p0_reg [2];
    coord_t                  c_p1_reg [2];
    coord_t                  c_p3_reg [2];
    coord_t                  c_p4_reg [2];

    coord_t                  d_p0_reg   [2];
    coord_t                  d_p1_reg   [2];
    coord_t                  d_p3_reg   [2];
    coord_t                  d_p4_reg   [2];
    logic signed [DW-1:0]    d_diff_reg [2];

    logic signed [DW-1:0]    hsum [2];
    coord_t                  e_p0_reg   [2];
    coord_t                  e_p1_reg   [2];
    coord_t                  e_p3_reg   [2];
    coord_t                  e_p4_reg   [2];
    logic signed [EW-1:0]    e_prod_reg [2];
    logic signed [DW-1:0]    e_half_reg [2];

    logic signed [EW-1:0]    tsum [2];
    logic signed [TW-1:0]    trq  [2];
    logic signed [SAT_W-1:0] apex_x;
    logic signed [SAT_W-1:0] apex_y;
    pts_t                    res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[4:0], start};
    end

    assign in0[0] = p0.x;
    assign in0[1] = p0.y;
    assign in4[0] = p4.x;
    assign in4[1] = p4.y;

    // stage a: difference and its magnitude
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            dif[ax]  = $signed({in4[ax][COORD_WIDTH-1], in4[ax]})
                     - $signed({in0[ax][COORD_WIDTH-1], in0[ax]});
            ndif[ax] = -dif[ax];
        end
    end

    // stage c: thirds and the two third points
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            lpos[ax] = {2'b00, b_prod_reg[ax][PW-1:DIV3_SHIFT]};
            lsig[ax] = b_neg_reg[ax] ? -$signed(lpos[ax]) : $signed(lpos[ax]);
            s1[ax]   = $signed({{3{b_p0_reg[ax][COORD_WIDTH-1]}}, b_p0_reg[ax]})
                     + $signed({{2{lsig[ax][DW-1]}}, lsig[ax]});
            s3[ax]   = $signed({{3{b_p4_reg[ax][COORD_WIDTH-1]}}, b_p4_reg[ax]})
                     - $signed({{2{lsig[ax][DW-1]}}, lsig[ax]});
        end
    end

    // stage e: halves truncated toward zero
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            hsum[ax] = d_diff_reg[ax]
                     + $signed({{(DW - 1){1'b0}}, d_diff_reg[ax][DW-1]});
        end
    end

    // stage f: q10 products truncated toward zero, apex sums
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            tsum[ax] = e_prod_reg[ax]
                     + $signed({{(EW - Q_FRAC){1'b0}}, {Q_FRAC{e_prod_reg[ax][EW-1]}}});
            trq[ax]  = tsum[ax][EW-1:Q_FRAC];
        end
        // apex x uses p/2 and q*sin, apex y uses -p*sin and q/2
        apex_x = $signed({{3{e_p1_reg[0][COORD_WIDTH-1]}}, e_p1_reg[0]})
               + $signed({{2{e_half_reg[0][DW-1]}}, e_half_reg[0]})
               + $signed({trq[1][TW-1], trq[1]});
        apex_y = $signed({{3{e_p1_reg[1][COORD_WIDTH-1]}}, e_p1_reg[1]})
               - $signed({trq[0][TW-1], trq[0]})
               + $signed({{2{e_half_reg[1][DW-1]}}, e_half_reg[1]});
    end

    always_ff @(posedge clk)
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            a_p0_reg[ax]  <= in0[ax];
            a_p4_reg[ax]  <= in4[ax];
            a_neg_reg[ax] <= dif[ax][DW-1];
            a_mag_reg[ax] <= dif[ax][DW-1] ? ndif[ax][COORD_WIDTH-1:0]
                                           : dif[ax][COORD_WIDTH-1:0];

            b_p0_reg[ax]   <= a_p0_reg[ax];
            b_p4_reg[ax]   <= a_p4_reg[ax];
            b_neg_reg[ax]  <= a_neg_reg[ax];
            b_prod_reg[ax] <= PW'(a_mag_reg[ax]) * PW'(DIV3_RECIP);

            c_p0_reg[ax] <= b_p0_reg[ax];
            c_p4_reg[ax] <= b_p4_reg[ax];
            c_p1_reg[ax] <= sat(s1[ax]);
            c_p3_reg[ax] <= sat(s3[ax]);

            d_p0_reg[ax]   <= c_p0_reg[ax];
            d_p1_reg[ax]   <= c_p1_reg[ax];
            d_p3_reg[ax]   <= c_p3_reg[ax];
            d_p4_reg[ax]   <= c_p4_reg[ax];
            d_diff_reg[ax] <= $signed({c_p3_reg[ax][COORD_WIDTH-1], c_p3_reg[ax]})
                            - $signed({c_p1_reg[ax][COORD_WIDTH-1], c_p1_reg[ax]});

            e_p0_reg[ax]   <= d_p0_reg[ax];
            e_p1_reg[ax]   <= d_p1_reg[ax];
            e_p3_reg[ax]   <= d_p3_reg[ax];
            e_p4_reg[ax]   <= d_p4_reg[ax];
            e_prod_reg[ax] <= d_diff_reg[ax] * SIN_Q10;
            e_half_reg[ax] <= hsum[ax] >>> 1;
        end
        // result holds until the next segment reaches the last stage
        if (v_reg[4])
        begin
            res_reg[0].x <= e_p0_reg[0];
            res_reg[0].y <= e_p0_reg[1];
            res_reg[1].x <= e_p1_reg[0];
            res_reg[1].y <= e_p1_reg[1];
            res_reg[2].x <= sat(apex_x);
            res_reg[2].y <= sat(apex_y);
            res_reg[3].x <= e_p3_reg[0];
            res_reg[3].y <= e_p3_reg[1];
            res_reg[4].x <= e_p4_reg[0];
            res_reg[4].y <= e_p4_reg[1];
        end
    end

    assign done = v_reg[5];
    assign res  = res_reg;

endmodule

FILE: rtl/ksd_walk.sv
// back part: depth-first walk over the subdivision tree, level stack memory,
// output register; depends on ksd_pkg and drives ksd_geom
module ksd_walk
    import ksd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  q_item_t   q_item,
    output logic      g_start,
    output point_t    g_p0,
    output point_t    g_p4,
    input  logic      g_done,
    input  pts_t      g_res,
    output logic      leaf_valid,
    input  logic      leaf_stall,
    output leaf_out_t leaf
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_LEAF  = 4'b0100,
        ST_FETCH = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [LW-1:0] level_reg, level_next;
    logic [LW-1:0] top_reg, top_next;
    logic [IW-1:0] fetch_reg, fetch_next;
    logic [1:0]    child_reg [MAX_DEPTH];
    logic [1:0]    child_next [MAX_DEPTH];
    logic          out_valid_reg, out_valid_next;
    leaf_out_t     out_reg;

    // one row per level: the five points of the open segment
    pts_t          mem [MAX_DEPTH];
    pts_t          rd_row_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          rd_re;

    logic          found;
    logic [IW-1:0] sel;
    logic          last;
    logic          out_free;
    logic          out_load;
    logic [1:0]    fchild;

    // nearest ancestor level that still has a child to visit
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            if ((LW'(i) < top_reg) && (child_reg[i] != LAST_CHILD))
            begin
                found = 1'b1;
                sel   = IW'(i);
            end
        end
        last = !found;
    end

    assign out_free = !out_valid_reg || !leaf_stall;
    assign fchild   = child_reg[fetch_reg];

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        top_next   = top_reg;
        fetch_next = fetch_reg;
        for (int i = 0; i < MAX_DEPTH; i++)
            child_next[i] = child_reg[i];
        g_start   = 1'b0;
        g_p0      = g_res[0];
        g_p4      = g_res[1];
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = IW'(level_reg - LW'(1));
        rd_re     = 1'b0;
        out_load  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                g_p0.x = q_item.seg.start_x;
                g_p0.y = q_item.seg.start_y;
                g_p4.x = q_item.seg.end_x;
                g_p4.y = q_item.seg.end_y;
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    g_start    = 1'b1;
                    level_next = q_item.level;
                    top_next   = q_item.level;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (g_done)
                begin
                    if (level_reg == '0)
                        state_next = ST_LEAF;
                    else
                    begin
                        // push the points and descend into child 0
                        mem_we                             = 1'b1;
                        child_next[IW'(level_reg - LW'(1))] = '0;
                        g_start                            = 1'b1;
                        level_next                         = level_reg - LW'(1);
                    end
                end
            end
            ST_LEAF:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (last)
                        state_next = ST_IDLE;
                    else
                    begin
                        child_next[sel] = child_reg[sel] + 2'd1;
                        fetch_next      = sel;
                        level_next      = LW'(sel);
                        rd_re           = 1'b1;
                        state_next      = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                g_p0       = rd_row_reg[3'(fchild)];
                g_p4       = rd_row_reg[3'(fchild) + 3'd1];
                g_start    = 1'b1;
                state_next = ST_CALC;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (!leaf_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            top_reg       <= '0;
            fetch_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_DEPTH; i++)
                child_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            top_reg       <= top_next;
            fetch_reg     <= fetch_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < MAX_DEPTH; i++)
                child_reg[i] <= child_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= g_res;
        if (rd_re)
            rd_row_reg <= mem[sel];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.pt0_x     <= g_res[0].x;
            out_reg.pt0_y     <= g_res[0].y;
            out_reg.pt1_x     <= g_res[1].x;
            out_reg.pt1_y     <= g_res[1].y;
            out_reg.pt2_x     <= g_res[2].x;
            out_reg.pt2_y     <= g_res[2].y;
            out_reg.pt3_x     <= g_res[3].x;
            out_reg.pt3_y     <= g_res[3].y;
            out_reg.pt4_x     <= g_res[4].x;
            out_reg.pt4_y     <= g_res[4].y;
            out_reg.last_leaf <= last;
        end
    end

    assign leaf_valid = out_valid_reg;
    assign leaf       = out_reg;

    property p_done_in_calc;
        @(posedge clk) disable iff (!rst_n) g_done |-> (state_reg == ST_CALC);
    endproperty
    a_done_in_calc: assert property (p_done_in_calc)
        else $error("geometry result arrived outside calc");

    property p_leaf_level;
        @(posedge clk) disable iff (!rst_n) (state_reg == ST_LEAF) |-> (level_reg == '0);
    endproperty
    a_leaf_level: assert property (p_leaf_level)
        else $error("leaf emitted above level zero");

    property p_pop_valid;
        @(posedge clk) disable iff (!rst_n) q_pop |-> q_valid;
    endproperty
    a_pop_valid: assert property (p_pop_valid) else $error("pop from empty queue");

    property p_fetch_index;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_FETCH) |-> (LW'(fetch_reg) < top_reg);
    endproperty
    a_fetch_index: assert property (p_fetch_index)
        else $error("fetch from a level outside the tree");

endmodule

FILE: rtl/koch_segment_subdivider.sv
// koch segment subdivider, top level: front queue, geometry pipeline, tree walker
// the first leaf word of a segment follows one geometry pass per level, from its level down to zero
// one geometry pipeline of six stages serves every segment of the tree, one segment at a time;
//   the walker takes the next input word only after the last leaf of the one before,
//   and output stalls hold the walk
// reset: depth returns to 3, queue and output register empty, walker idle
module koch_segment_subdivider
    import ksd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // depth register write
    input  logic                 cfg_we,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    // input segment channel
    input  logic                 seg_valid,
    output logic                 seg_stall,
    input  seg_in_t              seg,
    // leaf result channel
    output logic                 leaf_valid,
    input  logic                 leaf_stall,
    output leaf_out_t            leaf
);

    // front to back queue handshake
    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    // walker to geometry pipeline
    logic    g_start;
    point_t  g_p0;
    point_t  g_p4;
    logic    g_done;
    pts_t    g_res;

    // front: takes segments, tags each with its level, buffers two words
    ksd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // thirds and apex for one segment, result held until the next one finishes
    ksd_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .start (g_start),
        .p0    (g_p0),
        .p4    (g_p4),
        .done  (g_done),
        .res   (g_res)
    );

    // depth-first walk, level stack and leaf output register
    ksd_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .g_start    (g_start),
        .g_p0       (g_p0),
        .g_p4       (g_p4),
        .g_done     (g_done),
        .g_res      (g_res),
        .leaf_valid (leaf_valid),
        .leaf_stall (leaf_stall),
        .leaf       (leaf)
    );

endmodule
